[rtl/mlpsi_pkg.sv]
// Shared types, codes, widths and the sigmoid lookup table for the MLP inference block.
package mlpsi_pkg;

    localparam int MAX_LAYERS_DEF   = 4;
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int WEIGHT_WORDS_DEF = 32768;
    localparam int BIAS_WORDS_DEF   = 256;
    localparam int MAX_OUTPUTS_DEF  = 64;

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 15;
    localparam int VALUE_W  = 16;
    localparam int FRAC_W   = 12;
    localparam int SIG_W    = 13;
    localparam int IDX_W    = 6;
    localparam int SIZE_W   = 11;
    localparam int LCOUNT_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 11;
    localparam int SIZE_REGS = 4;
    localparam int SIG_ENTRIES = 256;

    typedef enum logic [CMD_W-1:0] {
        CMD_WEIGHT = 2'd0,
        CMD_BIAS   = 2'd1,
        CMD_INPUT  = 2'd2
    } cmd_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYER_COUNT  = 3'd0,
        REG_LAYER_SIZE_0 = 3'd1,
        REG_LAYER_SIZE_1 = 3'd2,
        REG_LAYER_SIZE_2 = 3'd3,
        REG_LAYER_SIZE_3 = 3'd4
    } reg_idx_e;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [ADDR_W-1:0]         address;
        logic signed [VALUE_W-1:0] value;
    } mlpsi_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] neuron_index;
        logic [SIG_W-1:0] activation;
        logic [IDX_W-1:0] best_class;
        logic             last_flag;
    } mlpsi_out_t;

    typedef struct packed {
        logic acc_load;
        logic term_valid;
    } mlpsi_mac_ctrl_t;

    typedef logic [SIG_ENTRIES-1:0][SIG_W-1:0] sig_tab_t;

    // 4096/(1+e^-t) at bin centers, built at elaboration with shift-subtract division
    function automatic sig_tab_t build_sig_tab();
        sig_tab_t     t;
        logic [127:0] e;
        logic [127:0] d;
        logic [127:0] n;
        logic [127:0] rem;
        logic [63:0]  q;
        t = '0;
        e = 128'd4162825043;
        for (int j = 0; j < 128; j++) begin
            d   = (128'd1 << 32) + e;
            n   = (128'd1 << 44) + (d >> 1);
            rem = '0;
            q   = '0;
            for (int i = 63; i >= 0; i--) begin
                rem = {rem[126:0], n[i]};
                if (rem >= d) begin
                    rem  = rem - d;
                    q[i] = 1'b1;
                end
            end
            t[128 + j] = q[SIG_W-1:0];
            t[127 - j] = SIG_W'(13'd4096 - q[SIG_W-1:0]);
            e = (e * 128'd4034748382 + (128'd1 << 31)) >> 32;
        end
        return t;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

[rtl/mlpsi_mac.sv]
// Shared multiply-accumulate unit with clamp and sigmoid table lookup.
module mlpsi_mac import mlpsi_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mlpsi_mac_ctrl_t           ctrl,
    input  logic signed [VALUE_W-1:0] bias,
    input  logic signed [VALUE_W-1:0] weight,
    input  logic signed [VALUE_W-1:0] act,
    output logic                      busy,
    output logic [SIG_W-1:0]          sig
);

    localparam int ACC_W = 2 * VALUE_W + 2 + $clog2(MAX_WIDTH);
    localparam logic signed [ACC_W-1:0] Z_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Z_MIN = ACC_W'(-32768);

    logic signed [2*VALUE_W-1:0] prod_reg;
    logic                        v2_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     z_full;
    logic [VALUE_W-1:0]          z_sat;
    logic [7:0]                  tab_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= ctrl.term_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.term_valid)
        begin
            prod_reg <= weight * act;
        end
        if (ctrl.acc_load)
        begin
            acc_reg <= ACC_W'(bias) <<< FRAC_W;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // floor division by 4096, then saturate to Q4.12
    always_comb
    begin
        z_full = acc_reg >>> FRAC_W;
        if (z_full > Z_MAX)
        begin
            z_sat = VALUE_W'(Z_MAX);
        end
        else if (z_full < Z_MIN)
        begin
            z_sat = VALUE_W'(Z_MIN);
        end
        else
        begin
            z_sat = z_full[VALUE_W-1:0];
        end
        tab_idx = {~z_sat[VALUE_W-1], z_sat[VALUE_W-2:VALUE_W-8]};
    end

    assign sig  = SIG_TAB[tab_idx];
    assign busy = v2_reg;

endmodule

[rtl/mlp_sigmoid_inference.sv]
// Top level of the fully connected sigmoid inference block: stores, sequencer, output register.
//
// Load items (cmd 0 weight, cmd 1 bias) and input activations (cmd 2) are accepted while
// in_stall is low. The activation that completes an image starts inference and the block raises
// in_stall until the last result is loaded into the output register. Inference runs on one
// shared 16x16 multiply-accumulate unit fed from single-port-read weight, bias and activation
// memories: each neuron of layer L takes a bias read, one product per cycle over size(L-1)
// inputs, a pipeline drain and one write-back, and a stalled output side holds back the
// write-back of each final-layer result. Weights are read in address order across rows and
// layers, so the weight address is a plain wrapping counter. Results come out one per output
// neuron through a single output register; the last one carries last_flag and the
// first-maximum best_class. Layer activations ping-pong between two buffers; the final layer is
// emitted directly and not stored. Configuration is written through cfg_we / cfg_index /
// cfg_data; the user must write it only while the block is idle, which the block does not enforce.
module mlp_sigmoid_inference import mlpsi_pkg::*; #(
    parameter int MAX_LAYERS   = MAX_LAYERS_DEF,
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int WEIGHT_WORDS = WEIGHT_WORDS_DEF,
    parameter int BIAS_WORDS   = BIAS_WORDS_DEF,
    parameter int MAX_OUTPUTS  = MAX_OUTPUTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mlpsi_in_t            in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mlpsi_out_t           out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int AIW  = $clog2(MAX_WIDTH);
    localparam int WAW  = $clog2(WEIGHT_WORDS);
    localparam int BAW  = $clog2(BIAS_WORDS);
    localparam int SZW  = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int TOP_LAYERS = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
    localparam int OUT_CAP = (MAX_OUTPUTS < MAX_WIDTH) ? MAX_OUTPUTS : MAX_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROW   = 5'b00010,
        S_MAC   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_STORE = 5'b10000
    } state_t;

    // configuration
    logic [LCOUNT_W-1:0] layer_count_reg;
    logic [SIZE_W-1:0]   layer_size_reg [SIZE_REGS];

    // sequencer
    state_t         state_reg;
    state_t         state_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  sz_reg [SIZE_REGS];
    logic [1:0]     left_reg;
    logic [CW-1:0]  row_reg;
    logic [CW-1:0]  col_reg;
    logic [WAW-1:0] waddr_reg;
    logic [BAW-1:0] baddr_reg;
    logic           v1_reg;
    logic           src_b_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [SIG_W-1:0] best_val_reg;
    logic           out_valid_reg;
    mlpsi_out_t     out_data_reg;

    // memories
    logic signed [VALUE_W-1:0] wmem [WEIGHT_WORDS];
    logic signed [VALUE_W-1:0] bmem [BIAS_WORDS];
    logic signed [VALUE_W-1:0] amem_a [MAX_WIDTH];
    logic signed [VALUE_W-1:0] amem_b [MAX_WIDTH];
    logic signed [VALUE_W-1:0] w_rd_reg;
    logic signed [VALUE_W-1:0] b_rd_reg;
    logic signed [VALUE_W-1:0] aa_rd_reg;
    logic signed [VALUE_W-1:0] ab_rd_reg;
    logic                      rd_sel_b_reg;

    logic            in_acc;
    logic            is_input;
    logic            fire;
    logic [CW-1:0]   eff0;
    logic [CW-1:0]   eff_all [SIZE_REGS];
    logic [1:0]      nl_m1;
    logic            last_layer;
    logic [CW-1:0]   nout_cur;
    logic            row_last;
    logic            out_free;
    logic            store_go;
    logic            store_wr;
    logic            issue;
    logic            better;
    logic [IDX_W-1:0] best_idx_next;
    logic [SIG_W-1:0] sig;
    logic            mac_busy;
    mlpsi_mac_ctrl_t mac_ctrl;
    logic            we_a;
    logic [AIW-1:0]  addr_a;
    logic signed [VALUE_W-1:0] data_a;

    function automatic logic [CW-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SZW-1:0] x;
        x = SZW'(s);
        if (x == '0)
        begin
            x = SZW'(1);
        end
        if (x > SZW'(MAX_WIDTH))
        begin
            x = SZW'(MAX_WIDTH);
        end
        return CW'(x);
    endfunction

    function automatic logic [1:0] layers_m1(input logic [LCOUNT_W-1:0] n);
        logic [LCOUNT_W-1:0] x;
        x = n;
        if (x < LCOUNT_W'(2))
        begin
            x = LCOUNT_W'(2);
        end
        if (x > LCOUNT_W'(TOP_LAYERS))
        begin
            x = LCOUNT_W'(TOP_LAYERS);
        end
        return 2'(x - LCOUNT_W'(1));
    endfunction

    always_comb
    begin
        for (int k = 0; k < SIZE_REGS; k++)
        begin
            eff_all[k] = eff_size(layer_size_reg[k]);
        end
    end

    assign eff0     = eff_all[0];
    assign nl_m1    = layers_m1(layer_count_reg);
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign is_input = in_acc && (in_data.cmd == CMD_INPUT);
    assign fire     = is_input && ((CW+1)'(count_reg) + 1'b1 >= (CW+1)'(eff0));

    assign last_layer = (left_reg == 2'd1);
    assign nout_cur   = (last_layer && sz_reg[1] > CW'(OUT_CAP)) ? CW'(OUT_CAP) : sz_reg[1];
    assign row_last   = (row_reg == nout_cur - 1'b1);
    assign out_free   = !out_valid_reg || !out_stall;
    assign store_go   = (state_reg == S_STORE) && (!last_layer || out_free);
    assign store_wr   = store_go && !last_layer;
    assign issue      = (state_reg == S_MAC);

    // first maximum: a later neuron wins only when strictly larger
    assign better        = (row_reg == '0) || (sig > best_val_reg);
    assign best_idx_next = better ? IDX_W'(row_reg) : best_idx_reg;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg   <= LCOUNT_W'(3);
            layer_size_reg[0] <= SIZE_W'(784);
            layer_size_reg[1] <= SIZE_W'(30);
            layer_size_reg[2] <= SIZE_W'(10);
            layer_size_reg[3] <= SIZE_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LAYER_COUNT:  layer_count_reg   <= cfg_data[LCOUNT_W-1:0];
                REG_LAYER_SIZE_0: layer_size_reg[0] <= cfg_data;
                REG_LAYER_SIZE_1: layer_size_reg[1] <= cfg_data;
                REG_LAYER_SIZE_2: layer_size_reg[2] <= cfg_data;
                REG_LAYER_SIZE_3: layer_size_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    state_next = S_ROW;
                end
            end
            S_ROW:   state_next = S_MAC;
            S_MAC:
            begin
                if (col_reg == sz_reg[0] - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!v1_reg && !mac_busy)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                if (store_go)
                begin
                    state_next = (last_layer && row_last) ? S_IDLE : S_ROW;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            waddr_reg     <= '0;
            baddr_reg     <= '0;
            v1_reg        <= 1'b0;
            src_b_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_val_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SIZE_REGS; k++)
            begin
                sz_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;

            if (is_input)
            begin
                count_reg <= fire ? '0 : count_reg + 1'b1;
            end

            if (fire)
            begin
                for (int k = 0; k < SIZE_REGS; k++)
                begin
                    sz_reg[k] <= eff_all[k];
                end
                left_reg  <= nl_m1;
                row_reg   <= '0;
                waddr_reg <= '0;
                baddr_reg <= '0;
                src_b_reg <= 1'b0;
            end

            if (state_reg == S_ROW)
            begin
                col_reg <= '0;
            end
            else if (issue)
            begin
                col_reg   <= col_reg + 1'b1;
                waddr_reg <= (waddr_reg == WAW'(WEIGHT_WORDS - 1)) ? '0 : waddr_reg + 1'b1;
            end

            // a new result loads the register; otherwise an accepted one empties it
            if (store_go && last_layer)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (store_go)
            begin
                baddr_reg <= (baddr_reg == BAW'(BIAS_WORDS - 1)) ? '0 : baddr_reg + 1'b1;
                if (row_last)
                begin
                    row_reg   <= '0;
                    left_reg  <= left_reg - 1'b1;
                    src_b_reg <= !src_b_reg;
                    for (int k = 0; k < SIZE_REGS - 1; k++)
                    begin
                        sz_reg[k] <= sz_reg[k + 1];
                    end
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                end
                if (last_layer)
                begin
                    best_idx_reg  <= best_idx_next;
                    if (better)
                    begin
                        best_val_reg <= sig;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (store_go && last_layer)
        begin
            out_data_reg.neuron_index <= IDX_W'(row_reg);
            out_data_reg.activation   <= sig;
            out_data_reg.best_class   <= row_last ? best_idx_next : '0;
            out_data_reg.last_flag    <= row_last;
        end
    end

    // weight and bias stores
    always_ff @(posedge clk)
    begin
        if (in_acc && in_data.cmd == CMD_WEIGHT && 32'(in_data.address) < WEIGHT_WORDS)
        begin
            wmem[WAW'(in_data.address)] <= in_data.value;
        end
        if (issue)
        begin
            w_rd_reg <= wmem[waddr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && in_data.cmd == CMD_BIAS && 32'(in_data.address) < BIAS_WORDS)
        begin
            bmem[BAW'(in_data.address)] <= in_data.value;
        end
        if (state_reg == S_ROW)
        begin
            b_rd_reg <= bmem[baddr_reg];
        end
    end

    // activation buffers: inputs land in A, layers ping-pong between A and B
    assign we_a   = is_input || (store_wr && src_b_reg);
    assign addr_a = is_input ? count_reg[AIW-1:0] : row_reg[AIW-1:0];
    assign data_a = is_input ? in_data.value : VALUE_W'(sig);

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            amem_a[addr_a] <= data_a;
        end
        if (issue)
        begin
            aa_rd_reg <= amem_a[col_reg[AIW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr && !src_b_reg)
        begin
            amem_b[row_reg[AIW-1:0]] <= VALUE_W'(sig);
        end
        if (issue)
        begin
            ab_rd_reg    <= amem_b[col_reg[AIW-1:0]];
            rd_sel_b_reg <= src_b_reg;
        end
    end

    assign mac_ctrl.acc_load   = issue && (col_reg == '0);
    assign mac_ctrl.term_valid = v1_reg;

    mlpsi_mac #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .bias   (b_rd_reg),
        .weight (w_rd_reg),
        .act    (rd_sel_b_reg ? ab_rd_reg : aa_rd_reg),
        .busy   (mac_busy),
        .sig    (sig)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/mlpsi_checker.sv]
// Port-level checks on the result channel of the MLP inference block, bound to the top level.
module mlpsi_checker import mlpsi_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input mlpsi_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.activation <= SIG_W'(4096))
        else $error("activation above one");

    a_best_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_flag |-> out_data.best_class == '0)
        else $error("best_class set on a non-final item");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result item right after reset");

endmodule

bind mlp_sigmoid_inference mlpsi_checker u_checker (.*);
